/* rtl/fpe_pkg.sv */
// shared types, constants and constant functions of the fractional polynomial expander
`timescale 1ns / 1ps
package fpe_pkg;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic signed [34:0] INT_CLAMP = 35'sd8589934591;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_DOMAIN = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    typedef struct packed {
        logic [1:0]         col;
        logic               last;
        logic               rep;
        logic [7:0]         pwr;
        logic [1:0]         mode;
        logic signed [30:0] ln;
    } t_tok;

    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] r;
        logic [63:0] bit_v;
        a = a_in;
        r = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (a >= r + bit_v) begin
                a = a - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return r;
    endfunction

    // 2^(2^-idx) in q1.30, by repeated truncated square roots of 2.0
    function automatic logic [63:0] exp_root(input int idx);
        logic [63:0] c;
        c = 64'h8000_0000;
        for (int k = 1; k <= idx; k++) begin
            c = isqrt64(c << 30);
        end
        return c;
    endfunction

endpackage

/* rtl/fpe_log2.sv */
// log2 of an unsigned q32.16 value in signed q24, one squaring per stage
`timescale 1ns / 1ps
module fpe_log2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  fpe_pkg::t_tok      i_tok,
    input  logic [47:0]        i_xi,
    output logic               o_valid,
    output fpe_pkg::t_tok      o_tok,
    output logic signed [30:0] o_l
);
    import fpe_pkg::*;

    logic [5:0]  k;
    logic [77:0] norm;
    logic [6:0]  ke;

    logic [24:0] r_v;
    t_tok        r_tok  [0:24];
    logic [30:0] r_m    [0:24];
    logic [23:0] r_frac [0:24];
    logic [5:0]  r_k    [0:24];

    // leading one
    always_comb begin
        k = '0;
        for (int b = 0; b < 48; b++) begin
            if (i_xi[b]) k = 6'(b);
        end
        norm = ({30'd0, i_xi} << 30) >> k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_tok[0]  <= i_tok;
            r_m[0]    <= norm[30:0];
            r_frac[0] <= '0;
            r_k[0]    <= k;
        end
    end

    for (genvar g = 1; g < 25; g++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] s;
        assign sq = 62'(r_m[g-1]) * 62'(r_m[g-1]);
        assign s  = sq[61:30];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= r_v[g-1];
            end
            if (i_en) begin
                r_tok[g]  <= r_tok[g-1];
                r_k[g]    <= r_k[g-1];
                r_m[g]    <= s[31] ? s[31:1] : s[30:0];
                r_frac[g] <= {r_frac[g-1][22:0], s[31]};
            end
        end
    end

    assign ke      = {1'b0, r_k[24]} - 7'd16;
    assign o_l     = $signed({ke, r_frac[24]});
    assign o_valid = r_v[24];
    assign o_tok   = r_tok[24];

endmodule

/* rtl/fpe_exp2.sv */
// 2^fraction in q1.30 as a product of constant roots, one root per stage
`timescale 1ns / 1ps
module fpe_exp2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  fpe_pkg::t_tok      i_tok,
    input  logic [27:0]        i_f,
    input  logic signed [10:0] i_n,
    output logic               o_valid,
    output fpe_pkg::t_tok      o_tok,
    output logic [30:0]        o_r,
    output logic signed [10:0] o_n
);
    import fpe_pkg::*;

    logic [28:1]        r_v;
    t_tok               r_tok [1:28];
    logic [27:0]        r_f   [1:28];
    logic signed [10:0] r_n   [1:28];
    logic [30:0]        r_r   [1:28];

    for (genvar g = 1; g <= 28; g++) begin : g_rt
        localparam logic [63:0] ROOT = exp_root(g);
        logic               v_in;
        t_tok               tok_in;
        logic [27:0]        f_in;
        logic signed [10:0] n_in;
        logic [30:0]        r_in;
        logic [61:0]        pr;
        if (g == 1) begin : g_first
            assign v_in   = i_valid;
            assign tok_in = i_tok;
            assign f_in   = i_f;
            assign n_in   = i_n;
            assign r_in   = 31'h4000_0000;
        end else begin : g_next
            assign v_in   = r_v[g-1];
            assign tok_in = r_tok[g-1];
            assign f_in   = r_f[g-1];
            assign n_in   = r_n[g-1];
            assign r_in   = r_r[g-1];
        end
        assign pr = 62'(r_in) * 62'(ROOT[30:0]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
            if (i_en) begin
                r_tok[g] <= tok_in;
                r_f[g]   <= f_in;
                r_n[g]   <= n_in;
                r_r[g]   <= f_in[28-g] ? pr[60:30] : r_in;
            end
        end
    end

    assign o_valid = r_v[28];
    assign o_tok   = r_tok[28];
    assign o_r     = r_r[28];
    assign o_n     = r_n[28];

endmodule

/* rtl/fractional_polynomial_expand_top.sv */
// top level of the fractional polynomial expander: config, column sequencer, pipeline
`timescale 1ns / 1ps
// datapath order: column sequencer, stage 1, stage 2, log2, ln, exponent, exp2, scale, output register
// throughput: one result column per cycle while the pipeline advances; a request yields power_count
//   columns (1 to 4), which the column sequencer issues into the pipeline one per cycle
// the whole pipeline advances together and halts while the output register holds
//   a result that is not taken
// reset (synchronous, active low) empties all stages and restores register defaults
module fractional_polynomial_expand_top #(
    parameter int MAX_POWERS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_column,
    output logic        o_last,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import fpe_pkg::*;

    // register indexes
    localparam logic [2:0] REG_PWR0   = 3'd0;
    localparam logic [2:0] REG_PWR1   = 3'd1;
    localparam logic [2:0] REG_PWR2   = 3'd2;
    localparam logic [2:0] REG_PWR3   = 3'd3;
    localparam logic [2:0] REG_COUNT  = 3'd4;
    localparam logic [2:0] REG_OFFSET = 3'd5;
    localparam logic [2:0] REG_INVSC  = 3'd6;
    localparam logic [2:0] REG_ZMODE  = 3'd7;
    localparam logic [2:0] MAXP       = 3'(MAX_POWERS);

    // configuration registers
    logic [7:0]  r_pwr [0:3];
    logic [2:0]  r_count;
    logic [31:0] r_offset;
    logic [31:0] r_inv;
    logic        r_zm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_pwr[i] <= 8'd16;
            r_count  <= 3'd1;
            r_offset <= '0;
            r_inv    <= 32'd65536;
            r_zm     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PWR0:   r_pwr[0] <= i_cfg_data[7:0];
                REG_PWR1:   r_pwr[1] <= i_cfg_data[7:0];
                REG_PWR2:   r_pwr[2] <= i_cfg_data[7:0];
                REG_PWR3:   r_pwr[3] <= i_cfg_data[7:0];
                REG_COUNT:  r_count  <= i_cfg_data[2:0];
                REG_OFFSET: r_offset <= i_cfg_data;
                REG_INVSC:  r_inv    <= i_cfg_data;
                REG_ZMODE:  r_zm     <= i_cfg_data[0];
                default:    r_zm     <= r_zm;
            endcase
        end
    end

    // whole pipeline moves when the output register is free or being taken
    logic adv;
    logic r_out_v;
    assign adv = !r_out_v || i_out_ready;

    // column sequencer: holds a request and issues one column token per cycle while the pipeline advances
    logic        r_busy;
    logic [31:0] r_smp;
    logic [1:0]  r_col;
    logic [1:0]  r_cnt;
    logic [1:0]  cnt_m1;
    logic        last_emit;
    logic        accept;

    always_comb begin
        if (r_count == 3'd0) cnt_m1 = 2'd0;
        else if (r_count > MAXP) cnt_m1 = 2'(MAXP - 3'd1);
        else cnt_m1 = 2'(r_count - 3'd1);
    end

    assign last_emit  = r_busy && (r_col == r_cnt);
    assign o_in_ready = adv && (!r_busy || last_emit);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            if (accept) r_busy <= 1'b1;
            else if (last_emit) r_busy <= 1'b0;
        end
        if (adv) begin
            if (accept) begin
                r_smp <= i_sample;
                r_col <= '0;
                r_cnt <= cnt_m1;
            end else if (r_busy) begin
                r_col <= r_col + 2'd1;
            end
        end
    end

    // stage 1: column token with its sample
    logic        r1_v;
    t_tok        r1_tok;
    logic [31:0] r1_smp;
    t_tok        tok0;

    always_comb begin
        tok0      = '0;
        tok0.col  = r_col;
        tok0.last = (r_col == r_cnt);
        tok0.pwr  = r_pwr[r_col];
        // same power as the column before: previous value times ln
        tok0.rep  = (r_col != 2'd0) && (r_pwr[r_col] == r_pwr[2'(r_col - 2'd1)]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= r_busy;
        end
        if (adv) begin
            r1_tok <= tok0;
            r1_smp <= r_smp;
        end
    end

    // stage 2: shift, scale and classify
    logic [32:0] sum;
    logic        pos;
    logic [63:0] prod;
    logic [47:0] xi;
    logic        xneg;
    t_tok        tok1;
    logic        r2_v;
    t_tok        r2_tok;
    logic [47:0] r2_xi;

    always_comb begin
        sum  = {r1_smp[31], r1_smp} + {r_offset[31], r_offset};
        pos  = !sum[32] && (sum != 33'd0);
        prod = 64'(sum[31:0]) * 64'(r_inv);
        xi   = pos ? prod[63:16] : '0;
        xneg = r1_smp[31] || (r1_smp == 32'd0);
        tok1 = r1_tok;
        if (r_zm && (xneg || xi == 48'd0)) tok1.mode = ST_ZERO;
        else if (xi == 48'd0) tok1.mode = ST_DOMAIN;
        else tok1.mode = ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
        if (adv) begin
            r2_tok <= tok1;
            r2_xi  <= xi;
        end
    end

    // log2 pipeline
    logic               lg_v;
    t_tok               lg_tok;
    logic signed [30:0] lg_l;

    fpe_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r2_v),
        .i_tok   (r2_tok),
        .i_xi    (r2_xi),
        .o_valid (lg_v),
        .o_tok   (lg_tok),
        .o_l     (lg_l)
    );

    // stage: ln = log2 * ln2, rounded half away from zero
    logic [29:0]        lmag;
    logic [59:0]        lnp;
    logic signed [30:0] lnm;
    t_tok               tok2;
    logic               r3_v;
    t_tok               r3_tok;
    logic signed [30:0] r3_l;

    always_comb begin
        lmag    = lg_l[30] ? 30'(-lg_l) : lg_l[29:0];
        lnp     = 60'(lmag) * 60'(LN2_Q30) + 60'(1 << 29);
        lnm     = $signed({1'b0, lnp[59:30]});
        tok2    = lg_tok;
        tok2.ln = lg_l[30] ? -lnm : lnm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= lg_v;
        end
        if (adv) begin
            r3_tok <= tok2;
            r3_l   <= lg_l;
        end
    end

    // stage: exponent y = p * log2 in q28, split into floor and fraction
    logic signed [38:0] y;
    logic               r4_v;
    t_tok               r4_tok;
    logic signed [38:0] r4_y;

    assign y = $signed({{31{r3_tok.pwr[7]}}, r3_tok.pwr}) * $signed({{8{r3_l[30]}}, r3_l});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
        if (adv) begin
            r4_tok <= r3_tok;
            r4_y   <= y;
        end
    end

    // exp2 pipeline on the fraction
    logic               ex_v;
    t_tok               ex_tok;
    logic [30:0]        ex_r;
    logic signed [10:0] ex_n;

    fpe_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r4_v),
        .i_tok   (r4_tok),
        .i_f     (r4_y[27:0]),
        .i_n     (r4_y[38:28]),
        .o_valid (ex_v),
        .o_tok   (ex_tok),
        .o_r     (ex_r),
        .o_n     (ex_n)
    );

    // stage: scale q1.30 mantissa by 2^n into q18.16, clamped
    logic signed [11:0] s;
    logic [11:0]        sh;
    logic [63:0]        vsh;
    logic [39:0]        rr;
    logic [33:0]        pw;
    logic               r5_v;
    t_tok               r5_tok;
    logic [33:0]        r5_pw;

    always_comb begin
        s   = {ex_n[10], ex_n} - 12'sd14;
        sh  = 12'(-s);
        vsh = '0;
        rr  = '0;
        pw  = '0;
        if (!s[11]) begin
            if (s > 12'sd32) begin
                pw = INT_CLAMP[33:0];
            end else begin
                vsh = {33'd0, ex_r} << s[5:0];
                pw  = (vsh > 64'(INT_CLAMP)) ? INT_CLAMP[33:0] : vsh[33:0];
            end
        end else if (sh < 12'd40) begin
            // round half up on the right shift
            rr = ({9'd0, ex_r} + (40'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
            pw = rr[33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= ex_v;
        end
        if (adv) begin
            r5_tok <= ex_tok;
            r5_pw  <= pw;
        end
    end

    // tail: column select, repeated-power product, saturation, output register
    logic signed [34:0] r_prev;
    logic [33:0]        aw;
    logic [29:0]        lnb;
    logic [63:0]        mp;
    logic [39:0]        q;
    logic signed [34:0] qs;
    logic signed [34:0] mulv;
    logic [30:0]        lnabs;
    logic [30:0]        lvm;
    logic signed [34:0] logv;
    logic signed [34:0] v;
    logic [31:0]        val;
    logic [1:0]         st;
    logic [31:0]        r_value;
    logic [1:0]         r_column;
    logic               r_last;
    logic [1:0]         r_status;

    always_comb begin
        aw    = r_prev[34] ? 34'(-r_prev) : r_prev[33:0];
        lnb   = r5_tok.ln[30] ? 30'(-r5_tok.ln) : r5_tok.ln[29:0];
        mp    = 64'(aw) * 64'(lnb) + 64'(1 << 23);
        q     = mp[63:24];
        qs    = (q > 40'(INT_CLAMP)) ? INT_CLAMP : $signed(35'(q));
        mulv  = (r_prev[34] ^ r5_tok.ln[30]) ? -qs : qs;
        lnabs = r5_tok.ln[30] ? 31'(-r5_tok.ln) : r5_tok.ln;
        lvm   = (lnabs + 31'd128) >> 8;
        logv  = r5_tok.ln[30] ? -$signed(35'(lvm)) : $signed(35'(lvm));
        if (r5_tok.rep) v = mulv;
        else if (r5_tok.pwr == 8'd0) v = logv;
        else v = $signed({1'b0, r5_pw});
        if (r5_tok.mode != ST_OK) begin
            val = '0;
            st  = r5_tok.mode;
        end else if (v > 35'sd2147483647) begin
            val = 32'h7FFF_FFFF;
            st  = ST_SAT;
        end else if (v < -35'sd2147483648) begin
            val = 32'h8000_0000;
            st  = ST_SAT;
        end else begin
            val = v[31:0];
            st  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r5_v;
        end
        if (adv) begin
            r_value  <= val;
            r_column <= r5_tok.col;
            r_last   <= r5_tok.last;
            r_status <= st;
            // unsaturated value feeds the next repeated column
            if (r5_v) r_prev <= v;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_value     = r_value;
    assign o_column    = r_column;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule
